@@ hdl/wpd_pkg.sv @@
// types and constants shared by the peak decimator cells and top level
// no dependencies
`default_nettype none

package wpd_pkg;

	localparam int MAX_CH   = 8;
	localparam int SAMPLE_W = 24;
	localparam int CH_W     = 3;
	localparam int CNT_W    = 4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef enum logic [1:0] {
		REQ_FRAME = 2'd0,
		REQ_FLUSH = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		REG_BUCKET_SIZE  = 2'd0,
		REG_NUM_CHANNELS = 2'd1
	} reg_idx_t;

	localparam logic [15:0]      BUCKET_RESET = 16'd512;
	localparam logic [CNT_W-1:0] NCH_RESET    = 4'd2;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [CNT_W-1:0] frame_channels;
		sample_t          sample_ch0;
		sample_t          sample_ch1;
		sample_t          sample_ch2;
		sample_t          sample_ch3;
		sample_t          sample_ch4;
		sample_t          sample_ch5;
		sample_t          sample_ch6;
		sample_t          sample_ch7;
	} in_word_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		sample_t         min_value;
		sample_t         max_value;
		logic            last;
	} out_word_t;

	typedef struct packed {
		sample_t min_v;
		sample_t max_v;
	} pair_t;

	typedef struct packed {
		logic upd;
		logic clr;
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/wpd_cell.sv @@
// one channel cell: running min/max tracker plus one slot of the output shift chain
// depends on wpd_pkg
`default_nettype none

module wpd_cell import wpd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire sample_t   sample,
	input  wire pair_t     slot_in,
	output pair_t          slot_out
);

	pair_t trk_q;
	pair_t slot_q;
	pair_t trk_nxt;

	// tracker value including this cycle's sample
	always_comb begin
		trk_nxt = trk_q;
		if (ctl.upd) begin
			if (sample < trk_q.min_v) trk_nxt.min_v = sample;
			if (sample > trk_q.max_v) trk_nxt.max_v = sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q <= '{min_v: SAMPLE_MAX, max_v: SAMPLE_MIN};
		end else if (ctl.clr || ctl.load) begin
			trk_q <= '{min_v: SAMPLE_MAX, max_v: SAMPLE_MIN};
		end else begin
			trk_q <= trk_nxt;
		end
	end

	// load wins over shift: it only coincides with the final pair leaving
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			slot_q <= trk_nxt;
		end else if (ctl.shift) begin
			slot_q <= slot_in;
		end
	end

	assign slot_out = slot_q;

endmodule

`default_nettype wire

@@ hdl/waveform_peak_decimator_top.sv @@
// min/max peak decimator top level: config registers, frame counter, cell chain
// depends on wpd_pkg and wpd_cell
//
//   port   direction   handshake               word
//   in     sink        in_valid / in_ready     in_word_t request
//   out    source      out_valid / out_ready   out_word_t min/max pair
//   cfg    sink        cfg_valid / cfg_ready   register index + data
//
// one request per cycle while in_ready; a bucket's n_eff pairs leave one per
// cycle while out_ready, from cell 0 of the shift chain, channel 0 first.
// frames keep going in while pairs drain; a request that would close another
// bucket waits until the last pair of the previous one is taken.
// reset clears the trackers, the count and the drain counter; cfg is always ready.
`default_nettype none

module waveform_peak_decimator_top import wpd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_word_t   in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_word_t       out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic [15:0]      bucket_size_q;
	logic [CNT_W-1:0] num_channels_q;
	logic [15:0]      frames_q;
	logic [CNT_W-1:0] remain_q;
	logic [CH_W-1:0]  chan_q;

	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] n_upd;
	logic [16:0]      frames_inc;
	logic [16:0]      size_eff;
	logic             is_frame;
	logic             is_flush;
	logic             is_clear;
	logic             emits;
	logic             drain_free;
	logic             in_acc;
	logic             out_acc;
	logic             do_emit;

	sample_t   samples [MAX_CH];
	pair_t     slots   [MAX_CH];
	cell_ctl_t ctl     [MAX_CH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_size_q  <= BUCKET_RESET;
			num_channels_q <= NCH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BUCKET_SIZE:  bucket_size_q  <= cfg_data;
				REG_NUM_CHANNELS: num_channels_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		n_eff = num_channels_q;
		if (num_channels_q == '0) n_eff = CNT_W'(1);
		if (num_channels_q > CNT_W'(MAX_CH)) n_eff = CNT_W'(MAX_CH);
		n_upd = (in_data.frame_channels < n_eff) ? in_data.frame_channels : n_eff;
	end

	assign is_frame   = in_data.req_type == REQ_FRAME;
	assign is_flush   = in_data.req_type == REQ_FLUSH;
	assign is_clear   = in_data.req_type == REQ_CLEAR;
	assign frames_inc = {1'b0, frames_q} + 17'd1;
	assign size_eff   = (bucket_size_q == '0) ? 17'd1 : {1'b0, bucket_size_q};
	assign emits      = (is_frame && frames_inc >= size_eff)
	                    || (is_flush && frames_q != '0);

	assign out_acc    = out_valid && out_ready;
	assign drain_free = (remain_q == '0) || (remain_q == CNT_W'(1) && out_ready);
	assign in_ready   = !emits || drain_free;
	assign in_acc     = in_valid && in_ready;
	assign do_emit    = in_acc && emits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= '0;
		end else if (in_acc) begin
			if (do_emit || is_clear) begin
				frames_q <= '0;
			end else if (is_frame) begin
				frames_q <= frames_inc[15:0];
			end
		end
	end

	// drain counter and channel index of the pair in cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
			chan_q   <= '0;
		end else if (do_emit) begin
			remain_q <= n_eff;
			chan_q   <= '0;
		end else if (out_acc) begin
			remain_q <= remain_q - CNT_W'(1);
			chan_q   <= chan_q + CH_W'(1);
		end
	end

	assign samples[0] = in_data.sample_ch0;
	assign samples[1] = in_data.sample_ch1;
	assign samples[2] = in_data.sample_ch2;
	assign samples[3] = in_data.sample_ch3;
	assign samples[4] = in_data.sample_ch4;
	assign samples[5] = in_data.sample_ch5;
	assign samples[6] = in_data.sample_ch6;
	assign samples[7] = in_data.sample_ch7;

	for (genvar c = 0; c < MAX_CH; c++) begin : g_cell
		pair_t nb_slot;

		assign ctl[c].upd   = in_acc && is_frame && (CNT_W'(c) < n_upd);
		assign ctl[c].clr   = in_acc && is_clear;
		assign ctl[c].load  = do_emit;
		assign ctl[c].shift = out_acc;

		// the end of the chain feeds sentinels; they are never shown
		if (c == MAX_CH - 1) begin : g_end
			assign nb_slot = '{min_v: SAMPLE_MAX, max_v: SAMPLE_MIN};
		end else begin : g_mid
			assign nb_slot = slots[c+1];
		end

		wpd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[c]),
			.sample   (samples[c]),
			.slot_in  (nb_slot),
			.slot_out (slots[c])
		);
	end

	assign out_valid          = remain_q != '0;
	assign out_data.channel   = chan_q;
	assign out_data.min_value = slots[0].min_v;
	assign out_data.max_value = slots[0].max_v;
	assign out_data.last      = remain_q == CNT_W'(1);

endmodule

`default_nettype wire

@@ dv/tb_waveform_peak_decimator_top.sv @@
// self-checking testbench for waveform_peak_decimator_top: directed and random requests,
// per-channel min/max predictor, in-order pair checking; depends on wpd_pkg and the rtl
module tb_waveform_peak_decimator_top import wpd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE_CYC   = 16;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 32;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_word_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_BUCKET_SIZE;
	logic [15:0] cfg_data = '0;

	waveform_peak_decimator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// predictor state
	sample_t          track_lo [MAX_CH];
	sample_t          track_hi [MAX_CH];
	int               frames_held;
	logic [15:0]      bucket_cfg = BUCKET_RESET;
	logic [CNT_W-1:0] nch_cfg = NCH_RESET;
	out_word_t        pairs_due [$];

	in_word_t req_fifo [$];
	int n_sent = 0;
	int n_popped = 0;
	int n_taken = 0;
	int n_errors = 0;
	int idle_cycles = 0;
	int burst_left = 8;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_span = 0;
	int stall_phase = 0;

	task automatic reset_trackers();
		for (int c = 0; c < MAX_CH; c++) begin
			track_lo[c] = SAMPLE_MAX;
			track_hi[c] = SAMPLE_MIN;
		end
		frames_held = 0;
	endtask

	function automatic int active_channels();
		int n;
		n = nch_cfg;
		if (n == 0)
			n = 1;
		if (n > MAX_CH)
			n = MAX_CH;
		return n;
	endfunction

	task automatic close_bucket();
		out_word_t p;
		int n;
		if (frames_held == 0)
			return;
		n = active_channels();
		for (int c = 0; c < n; c++) begin
			p.channel   = c[CH_W-1:0];
			p.min_value = track_lo[c];
			p.max_value = track_hi[c];
			p.last      = (c == n - 1);
			pairs_due.push_back(p);
		end
		reset_trackers();
	endtask

	task automatic predict_req(input in_word_t w);
		sample_t smp [MAX_CH];
		int n;
		int size;
		smp[0] = w.sample_ch0;
		smp[1] = w.sample_ch1;
		smp[2] = w.sample_ch2;
		smp[3] = w.sample_ch3;
		smp[4] = w.sample_ch4;
		smp[5] = w.sample_ch5;
		smp[6] = w.sample_ch6;
		smp[7] = w.sample_ch7;
		case (w.req_type)
			REQ_FLUSH: close_bucket();
			REQ_CLEAR: reset_trackers();
			REQ_FRAME: begin
				n = active_channels();
				if (w.frame_channels < n)
					n = w.frame_channels;
				for (int c = 0; c < n; c++) begin
					if (smp[c] < track_lo[c])
						track_lo[c] = smp[c];
					if (smp[c] > track_hi[c])
						track_hi[c] = smp[c];
				end
				frames_held++;
				size = (bucket_cfg == 0) ? 1 : bucket_cfg;
				// a lowered bucket size closes on the next frame
				if (frames_held >= size)
					close_bucket();
			end
			default: ;
		endcase
	endtask

	// all handshakes are observed here, at the rising edge
	always @(posedge clk) begin
		out_word_t e;
		if (out_valid && out_ready) begin
			if (pairs_due.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected pair: got ch=%0d min=%0d max=%0d last=%0b", $time,
					out_data.channel, out_data.min_value, out_data.max_value, out_data.last);
			end else begin
				e = pairs_due.pop_front();
				if (out_data.channel !== e.channel || out_data.min_value !== e.min_value ||
					out_data.max_value !== e.max_value || out_data.last !== e.last) begin
					n_errors++;
					$display("%0t: pair mismatch: exp ch=%0d min=%0d max=%0d last=%0b,",
						$time, e.channel, e.min_value, e.max_value, e.last,
						" got ch=%0d min=%0d max=%0d last=%0b",
						out_data.channel, out_data.min_value, out_data.max_value, out_data.last);
				end
			end
		end
		if (in_valid && in_ready) begin
			predict_req(in_data);
			n_taken++;
		end
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BUCKET_SIZE:  bucket_cfg = cfg_data;
				REG_NUM_CHANNELS: nch_cfg = cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sender: bursts of words with random gaps between them
	always @(negedge clk) begin
		if (n_popped != n_taken) begin
			// hold the word until it is taken
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (req_fifo.size() > 0) begin
			in_valid <= 1'b1;
			in_data  <= req_fifo.pop_front();
			n_popped++;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver stall pattern: one of four modes, chosen anew when stall_span runs out
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(50, 300);
		end
		stall_span--;
		stall_phase++;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (stall_phase % 5) != 0;
			default: out_ready <= (stall_phase % 16) >= 10;
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("tb_waveform_peak_decimator_top: errors");
			$finish;
		end
	end

	task automatic send_req(input in_word_t w);
		req_fifo.push_back(w);
		n_sent++;
		wait (n_taken == n_sent);
	endtask

	// wait for every pair due, then let any frame still in flight land
	task automatic settle();
		while (pairs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return sample_t'(int'($urandom_range(0, 64)) - 32);
			default: return sample_t'($urandom());
		endcase
	endfunction

	function automatic in_word_t make_frame(input logic [CNT_W-1:0] fc, input bit rnd,
		input sample_t v);
		in_word_t w;
		w.req_type       = REQ_FRAME;
		w.frame_channels = fc;
		w.sample_ch0 = rnd ? pick_sample() : v;
		w.sample_ch1 = rnd ? pick_sample() : v;
		w.sample_ch2 = rnd ? pick_sample() : v;
		w.sample_ch3 = rnd ? pick_sample() : v;
		w.sample_ch4 = rnd ? pick_sample() : v;
		w.sample_ch5 = rnd ? pick_sample() : v;
		w.sample_ch6 = rnd ? pick_sample() : v;
		w.sample_ch7 = rnd ? pick_sample() : v;
		return w;
	endfunction

	// non-frame request with junk in the other fields
	function automatic in_word_t make_req(input req_t r);
		in_word_t w;
		w = make_frame(CNT_W'($urandom_range(0, 15)), 1'b1, '0);
		w.req_type = r;
		return w;
	endfunction

	task automatic test_reset_config();
		send_req(make_req(REQ_FLUSH));
		send_req(make_frame(4'd2, 1'b1, '0));
		send_req(make_frame(4'd1, 1'b1, '0));
		send_req(make_req(REQ_NONE));
		send_req(make_frame(4'd8, 1'b1, '0));
		send_req(make_req(REQ_FLUSH));
		settle();
	endtask

	task automatic test_extremes();
		write_reg(REG_BUCKET_SIZE, 16'd4);
		write_reg(REG_NUM_CHANNELS, 16'd8);
		send_req(make_frame(4'd8, 1'b0, SAMPLE_MAX));
		send_req(make_frame(4'd8, 1'b0, SAMPLE_MIN));
		send_req(make_frame(4'd15, 1'b0, '0));
		send_req(make_frame(4'd8, 1'b0, '1));
		settle();
		// frames with no channels leave the sentinels in place
		write_reg(REG_BUCKET_SIZE, 16'd2);
		send_req(make_frame(4'd0, 1'b1, '0));
		send_req(make_frame(4'd0, 1'b1, '0));
		settle();
	endtask

	task automatic test_clear();
		send_req(make_frame(4'd8, 1'b1, '0));
		send_req(make_req(REQ_CLEAR));
		send_req(make_req(REQ_FLUSH));
		settle();
	endtask

	task automatic test_channel_limits();
		write_reg(REG_BUCKET_SIZE, 16'd0);
		write_reg(REG_NUM_CHANNELS, 16'd0);
		send_req(make_frame(4'd8, 1'b1, '0));
		settle();
		write_reg(REG_NUM_CHANNELS, 16'hfff);
		send_req(make_frame(4'd8, 1'b1, '0));
		settle();
	endtask

	task automatic test_bucket_lowered();
		write_reg(REG_BUCKET_SIZE, 16'd10);
		write_reg(REG_NUM_CHANNELS, 16'd3);
		repeat (3) send_req(make_frame(4'd3, 1'b1, '0));
		settle();
		write_reg(REG_BUCKET_SIZE, 16'd2);
		send_req(make_frame(4'd3, 1'b1, '0));
		settle();
		write_reg(REG_BUCKET_SIZE, 16'hffff);
		send_req(make_frame(4'd8, 1'b1, '0));
		send_req(make_frame(4'd5, 1'b1, '0));
		send_req(make_req(REQ_FLUSH));
		settle();
	endtask

	task automatic test_random();
		int r;
		logic [15:0] bsz;
		bit hold_off;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 9))
				0: bsz = 16'd0;
				1: bsz = 16'd1;
				7: bsz = 16'($urandom_range(7, 16));
				8: bsz = 16'd32;
				9: bsz = 16'hffff;
				default: bsz = 16'($urandom_range(2, 6));
			endcase
			write_reg(REG_BUCKET_SIZE, bsz);
			// upper data bits are don't-care for the channel count
			r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
			write_reg(REG_NUM_CHANNELS, {12'($urandom_range(0, 4095)), r[3:0]});
			hold_off = (ph == 3) || ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 82)
					send_req(make_frame(CNT_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(0, 15) : $urandom_range(1, 8)), 1'b1, '0));
				else if (r < 90)
					send_req(make_req(REQ_FLUSH));
				else if (r < 95)
					send_req(make_req(REQ_CLEAR));
				else
					send_req(make_req(REQ_NONE));
				if (hold_off && (i % 8) == 7)
					while (pairs_due.size() != 0)
						@(posedge clk);
			end
			if ($urandom_range(0, 1))
				send_req(make_req(REQ_FLUSH));
			settle();
		end
	endtask

	initial begin
		reset_trackers();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_reset_config();
		test_extremes();
		test_clear();
		test_channel_limits();
		test_bucket_lowered();
		test_random();
		settle();
		if (n_errors == 0)
			$display("tb_waveform_peak_decimator_top: clean");
		else
			$display("tb_waveform_peak_decimator_top: errors");
		$finish;
	end

endmodule
